@@ hdl/svpwm_pkg.sv @@
package svpwm_pkg;

	// Datapath geometry
	localparam int NPH         = 3;
	localparam int DATA_W      = 16;
	localparam int GAIN_W      = 15;
	localparam int GAIN_SHIFT  = 14;
	localparam int SCALE_SHIFT = 15;
	localparam int DIFF_W      = DATA_W + 1;
	localparam int PROD_W      = DIFF_W + GAIN_W + 1;
	localparam int HALF_W      = DATA_W - 1;
	localparam int SCALED_W    = HALF_W + DATA_W;
	localparam int CFG_IDX_W   = 2;

	// Register reset values
	localparam logic              RST_SVM_ENABLE   = 1'b1;
	localparam logic [GAIN_W-1:0] RST_INJ_GAIN     = 15'd18919;
	localparam logic [DATA_W-1:0] RST_TIMER_PERIOD = 16'd4250;

	// Saturation limits of a phase value
	localparam logic signed [DATA_W-1:0] PHASE_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] PHASE_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SVM_ENABLE   = 2'd0,
		CFG_INJ_GAIN     = 2'd1,
		CFG_TIMER_PERIOD = 2'd2
	} cfg_idx_t;

	typedef logic signed [DATA_W-1:0] phase_t;
	typedef logic [DATA_W-1:0]        duty_t;

	typedef struct packed {
		logic              svm_enable;
		logic [GAIN_W-1:0] injection_gain;
		logic [DATA_W-1:0] timer_period;
	} cfg_t;

endpackage

@@ hdl/svpwm_cfg.sv @@
module svpwm_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  svpwm_pkg::cfg_idx_t  wr_index,
	input  svpwm_pkg::duty_t     wr_data,
	output svpwm_pkg::cfg_t      cfg
);
	import svpwm_pkg::*;

	cfg_t cfg_q;

	// Decode the register index and latch the written field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.svm_enable     <= RST_SVM_ENABLE;
			cfg_q.injection_gain <= RST_INJ_GAIN;
			cfg_q.timer_period   <= RST_TIMER_PERIOD;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SVM_ENABLE:   cfg_q.svm_enable     <= wr_data[0];
				CFG_INJ_GAIN:     cfg_q.injection_gain <= wr_data[GAIN_W-1:0];
				CFG_TIMER_PERIOD: cfg_q.timer_period   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/svpwm_zseq.sv @@
module svpwm_zseq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  svpwm_pkg::cfg_t     cfg,
	input  logic                in_vld,
	input  svpwm_pkg::phase_t   va,
	input  svpwm_pkg::phase_t   vb,
	input  svpwm_pkg::phase_t   vc,
	output logic                out_vld,
	output svpwm_pkg::phase_t   ph_a,
	output svpwm_pkg::phase_t   ph_b,
	output svpwm_pkg::phase_t   ph_c
);
	import svpwm_pkg::*;

	phase_t                   v_in [NPH];
	phase_t                   hi;
	phase_t                   lo;
	logic signed [DIFF_W-1:0] hl_sum;
	logic signed [PROD_W-GAIN_SHIFT-1:0] shifted [NPH];
	phase_t                   sat_val [NPH];

	logic                      vld_s1, vld_s2, vld_s3, vld_s4;
	phase_t                    v_s1 [NPH];
	phase_t                    mid_s1;
	phase_t                    v_s2 [NPH];
	logic signed [DIFF_W-1:0]  diff_s2 [NPH];
	phase_t                    v_s3 [NPH];
	logic signed [PROD_W-1:0]  prod_s3 [NPH];
	phase_t                    ph_s4 [NPH];

	assign v_in[0] = va;
	assign v_in[1] = vb;
	assign v_in[2] = vc;

	// Find the largest and smallest command and their floored midpoint
	always_comb begin
		hi = va;
		lo = va;
		if (vb > hi) hi = vb;
		if (vc > hi) hi = vc;
		if (vb < lo) lo = vb;
		if (vc < lo) lo = vc;
		hl_sum = {hi[DATA_W-1], hi} + {lo[DATA_W-1], lo};
	end

	// Floor shift by the gain scale, then saturate to the phase range
	always_comb begin
		for (int i = 0; i < NPH; i++) begin
			shifted[i] = prod_s3[i][PROD_W-1:GAIN_SHIFT];
			if (shifted[i][PROD_W-GAIN_SHIFT-1:DATA_W-1] !=
					{(PROD_W-GAIN_SHIFT-DATA_W+1){shifted[i][DATA_W-1]}}) begin
				sat_val[i] = shifted[i][PROD_W-GAIN_SHIFT-1] ? PHASE_MIN : PHASE_MAX;
			end else begin
				sat_val[i] = shifted[i][DATA_W-1:0];
			end
		end
	end

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stages: midpoint, difference, gain product, saturate and select
	always_ff @(posedge clk) begin
		if (advance) begin
			mid_s1 <= hl_sum[DIFF_W-1:1];
			for (int i = 0; i < NPH; i++) begin
				v_s1[i]    <= v_in[i];
				v_s2[i]    <= v_s1[i];
				diff_s2[i] <= {v_s1[i][DATA_W-1], v_s1[i]} - {mid_s1[DATA_W-1], mid_s1};
				v_s3[i]    <= v_s2[i];
				prod_s3[i] <= PROD_W'(diff_s2[i]) *
					PROD_W'($signed({1'b0, cfg.injection_gain}));
				ph_s4[i]   <= cfg.svm_enable ? sat_val[i] : v_s3[i];
			end
		end
	end

	assign out_vld = vld_s4;
	assign ph_a    = ph_s4[0];
	assign ph_b    = ph_s4[1];
	assign ph_c    = ph_s4[2];

endmodule

@@ hdl/svpwm_scale.sv @@
module svpwm_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  svpwm_pkg::cfg_t     cfg,
	input  logic                in_vld,
	input  svpwm_pkg::phase_t   ph_a,
	input  svpwm_pkg::phase_t   ph_b,
	input  svpwm_pkg::phase_t   ph_c,
	output logic                out_vld,
	output svpwm_pkg::duty_t    duty_a,
	output svpwm_pkg::duty_t    duty_b,
	output svpwm_pkg::duty_t    duty_c
);
	import svpwm_pkg::*;

	phase_t              ph_in [NPH];
	logic [HALF_W-1:0]   half [NPH];
	duty_t               scaled [NPH];

	logic                vld_s5, vld_s6;
	logic [SCALED_W-1:0] prod_s5 [NPH];
	duty_t               duty_s6 [NPH];

	assign ph_in[0] = ph_a;
	assign ph_in[1] = ph_b;
	assign ph_in[2] = ph_c;

	// Offset by one in Q15 and halve: flip the sign bit, drop the lsb
	always_comb begin
		for (int i = 0; i < NPH; i++) begin
			half[i]   = {~ph_in[i][DATA_W-1], ph_in[i][DATA_W-2:1]};
			scaled[i] = prod_s5[i][SCALED_W-1:SCALE_SHIFT];
		end
	end

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (advance) begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
		end
	end

	// Scale by the timer period, then clamp to the period
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NPH; i++) begin
				prod_s5[i] <= half[i] * cfg.timer_period;
				duty_s6[i] <= (scaled[i] > cfg.timer_period) ? cfg.timer_period : scaled[i];
			end
		end
	end

	assign out_vld = vld_s6;
	assign duty_a  = duty_s6[0];
	assign duty_b  = duty_s6[1];
	assign duty_c  = duty_s6[2];

endmodule

@@ hdl/svpwm_duty_calc_core.sv @@
// Throughput: one request per cycle; six register stages (midpoint, difference,
// gain product, saturate, period product, clamp) advance together while unstalled.
// Reset: arst_n clears all valid bits asynchronously and loads the register
// defaults (injection on, gain 18919, period 4250); datapath registers are not reset.
module svpwm_duty_calc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  svpwm_pkg::phase_t    va,
	input  svpwm_pkg::phase_t    vb,
	input  svpwm_pkg::phase_t    vc,
	output logic                 out_valid,
	input  logic                 out_stall,
	output svpwm_pkg::duty_t     duty_a,
	output svpwm_pkg::duty_t     duty_b,
	output svpwm_pkg::duty_t     duty_c,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  svpwm_pkg::cfg_idx_t  cfg_index,
	input  svpwm_pkg::duty_t     cfg_data
);
	import svpwm_pkg::*;

	cfg_t   cfg;
	logic   advance;
	logic   mid_vld;
	phase_t ph_a, ph_b, ph_c;

	// Move the whole pipe unless a finished result is held by the sink
	assign advance   = ~out_valid | ~out_stall;
	assign in_stall  = ~advance;
	assign cfg_ready = 1'b1;

	svpwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	svpwm_zseq u_zseq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg),
		.in_vld  (in_valid),
		.va      (va),
		.vb      (vb),
		.vc      (vc),
		.out_vld (mid_vld),
		.ph_a    (ph_a),
		.ph_b    (ph_b),
		.ph_c    (ph_c)
	);

	svpwm_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg),
		.in_vld  (mid_vld),
		.ph_a    (ph_a),
		.ph_b    (ph_b),
		.ph_c    (ph_c),
		.out_vld (out_valid),
		.duty_a  (duty_a),
		.duty_b  (duty_b),
		.duty_c  (duty_c)
	);

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import svpwm_pkg::*;

	localparam int     PIPE_DEPTH       = 6;
	localparam int     LONG_HOLD        = 300;
	localparam int     BLOCK_LEN        = 100;
	localparam int     BLOCKS_PER_PHASE = 6;
	localparam longint Q15_OFFSET       = 32768;
	localparam int     CORNER_VALS [5]  = '{-32768, 32767, 0, -1, 1};
	// Index past the end of the register map, written to check it is ignored
	localparam cfg_idx_t CFG_SPARE      = cfg_idx_t'(2'd3);

	typedef struct packed {
		duty_t a;
		duty_t b;
		duty_t c;
	} duty_set_t;

	typedef enum bit {ROW_CMD, ROW_WR} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		bit          known;
		cfg_idx_t    idx;
		logic [15:0] data;
		phase_t      a;
		phase_t      b;
		phase_t      c;
		duty_set_t   want;
	} step_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	phase_t      va         = '0;
	phase_t      vb         = '0;
	phase_t      vc         = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	duty_t       duty_a;
	duty_t       duty_b;
	duty_t       duty_c;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index  = CFG_SVM_ENABLE;
	logic [15:0] cfg_data   = '0;

	// Shadow copy of the register map
	logic              sh_svm    = RST_SVM_ENABLE;
	logic [GAIN_W-1:0] sh_gain   = RST_INJ_GAIN;
	logic [DATA_W-1:0] sh_period = RST_TIMER_PERIOD;

	duty_set_t pending_duty [$];
	int        err_cnt       = 0;
	int        src_idle_pct  = 0;
	int        sink_idle_pct = 0;
	bit        burst_go      = 1'b0;
	logic      burst_hold    = 1'b0;

	svpwm_duty_calc_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.va        (va),
		.vb        (vb),
		.vc        (vc),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty_a    (duty_a),
		.duty_b    (duty_b),
		.duty_c    (duty_c),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Compute the compare values for one set of phase commands
	function automatic duty_set_t predict_duty(phase_t a, phase_t b, phase_t c);
		longint    v [3];
		longint    hi;
		longint    lo;
		longint    mid;
		longint    gain;
		longint    per;
		longint    half;
		longint    scaled [3];
		duty_set_t r;
		v[0] = a;
		v[1] = b;
		v[2] = c;
		gain = sh_gain;
		per  = sh_period;
		// Remove the min-max midpoint, apply gain and saturate
		if (sh_svm) begin
			hi = v[0];
			lo = v[0];
			for (int i = 1; i < NPH; i++) begin
				if (v[i] > hi) hi = v[i];
				if (v[i] < lo) lo = v[i];
			end
			mid = (hi + lo) >>> 1;
			for (int i = 0; i < NPH; i++) begin
				v[i] = ((v[i] - mid) * gain) >>> GAIN_SHIFT;
				if (v[i] > PHASE_MAX) v[i] = PHASE_MAX;
				if (v[i] < PHASE_MIN) v[i] = PHASE_MIN;
			end
		end
		// Offset, halve, scale by the period and clamp
		for (int i = 0; i < NPH; i++) begin
			half = (v[i] + Q15_OFFSET) >>> 1;
			if (half < 0) half = 0;
			scaled[i] = (half * per) >>> SCALE_SHIFT;
			if (scaled[i] > per) scaled[i] = per;
		end
		r.a = duty_t'(scaled[0]);
		r.b = duty_t'(scaled[1]);
		r.c = duty_t'(scaled[2]);
		return r;
	endfunction

	function automatic step_t mk_cmd(int a, int b, int c);
		step_t s;
		s = '{kind: ROW_CMD, known: 1'b0, idx: CFG_SVM_ENABLE, data: '0,
			a: phase_t'(a), b: phase_t'(b), c: phase_t'(c), want: '0};
		return s;
	endfunction

	function automatic step_t mk_chk(int a, int b, int c, int ea, int eb, int ec);
		step_t s;
		s = mk_cmd(a, b, c);
		s.known  = 1'b1;
		s.want.a = duty_t'(ea);
		s.want.b = duty_t'(eb);
		s.want.c = duty_t'(ec);
		return s;
	endfunction

	function automatic step_t mk_wr(cfg_idx_t idx, int d);
		step_t s;
		s = mk_cmd(0, 0, 0);
		s.kind = ROW_WR;
		s.idx  = idx;
		s.data = d[15:0];
		return s;
	endfunction

	// Offer one request, idling at random first, and log its expected result
	task automatic offer_cmd(phase_t a, phase_t b, phase_t c, duty_set_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		va       <= a;
		vb       <= b;
		vc       <= c;
		do @(posedge clk); while (in_stall);
		pending_duty.push_back(want);
	endtask

	// Write one register; drop valid only after the last of a burst
	task automatic write_reg(cfg_idx_t idx, logic [15:0] data, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (last) cfg_valid <= 1'b0;
		case (idx)
			CFG_SVM_ENABLE:   sh_svm    = data[0];
			CFG_INJ_GAIN:     sh_gain   = data[GAIN_W-1:0];
			CFG_TIMER_PERIOD: sh_period = data;
			default: ;
		endcase
	endtask

	// Stop offering and wait for every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_duty.size() != 0) @(posedge clk);
	endtask

	// Check results against the oldest expectation and drive the stall
	always @(posedge clk) begin : result_check
		duty_set_t want;
		if (out_valid && !out_stall) begin
			if (pending_duty.size() == 0) begin
				$error("unexpected result duty_a=%0d duty_b=%0d duty_c=%0d",
					duty_a, duty_b, duty_c);
				err_cnt++;
			end else begin
				want = pending_duty.pop_front();
				if (duty_a !== want.a) begin
					$error("duty_a: expected %0d, got %0d", want.a, duty_a);
					err_cnt++;
				end
				if (duty_b !== want.b) begin
					$error("duty_b: expected %0d, got %0d", want.b, duty_b);
					err_cnt++;
				end
				if (duty_c !== want.c) begin
					$error("duty_c: expected %0d, got %0d", want.c, duty_c);
					err_cnt++;
				end
			end
		end
		out_stall <= burst_hold || ($urandom_range(99) < sink_idle_pct);
	end

	// Hold the output off for a long stretch so the pipeline backs up
	initial begin
		wait (burst_go);
		@(posedge clk);
		burst_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		burst_hold <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		step_t       steps [$];
		duty_set_t   want;
		phase_t      a;
		phase_t      b;
		phase_t      c;
		logic [15:0] en_val;
		logic [15:0] gain_val;
		logic [15:0] per_val;
		int          sel;
		int          sum;

		// Directed requests; typed-in results assume the register state at that row
		steps.push_back(mk_chk(0, 0, 0, 2125, 2125, 2125));
		steps.push_back(mk_chk(32767, 32767, 32767, 2125, 2125, 2125));
		steps.push_back(mk_chk(-32768, -32768, -32768, 2125, 2125, 2125));
		steps.push_back(mk_chk(32767, -32768, 0, 4249, 0, 2125));
		steps.push_back(mk_cmd(21845, -21846, 0));
		steps.push_back(mk_cmd(-21846, 21845, 1000));
		steps.push_back(mk_cmd(12000, -6000, -6000));
		steps.push_back(mk_cmd(-1, 0, 1));
		// Large gain drives the scaled difference into saturation
		steps.push_back(mk_wr(CFG_INJ_GAIN, 32767));
		steps.push_back(mk_cmd(20000, -20000, 0));
		steps.push_back(mk_cmd(-32768, 32767, 32767));
		// Zero gain with injection on flattens every phase to mid-scale
		steps.push_back(mk_wr(CFG_INJ_GAIN, 0));
		steps.push_back(mk_chk(30000, -5, 123, 2125, 2125, 2125));
		// Pass-through, oversized gain data, full-scale period
		steps.push_back(mk_wr(CFG_SVM_ENABLE, 0));
		steps.push_back(mk_wr(CFG_INJ_GAIN, 16'hffff));
		steps.push_back(mk_wr(CFG_TIMER_PERIOD, 65535));
		steps.push_back(mk_cmd(32767, -32768, 0));
		steps.push_back(mk_cmd(21845, -21846, -1));
		// Zero period forces every compare value to zero
		steps.push_back(mk_wr(CFG_TIMER_PERIOD, 0));
		steps.push_back(mk_chk(32767, -32768, 0, 0, 0, 0));
		// Write to an unmapped index must leave the map alone
		steps.push_back(mk_wr(CFG_SPARE, 1234));
		steps.push_back(mk_chk(100, 200, 300, 0, 0, 0));
		// Only bit 0 of the enable data counts
		steps.push_back(mk_wr(CFG_SVM_ENABLE, 16'hfffe));
		steps.push_back(mk_wr(CFG_TIMER_PERIOD, 1));
		steps.push_back(mk_cmd(32767, 0, -32768));
		steps.push_back(mk_wr(CFG_SVM_ENABLE, 16'h0003));
		steps.push_back(mk_wr(CFG_INJ_GAIN, 18919));
		steps.push_back(mk_wr(CFG_TIMER_PERIOD, 4250));
		steps.push_back(mk_cmd(1, -1, 0));

		src_idle_pct  = 7;
		sink_idle_pct = 73;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (steps[i]) begin
			if (steps[i].kind == ROW_WR) begin
				if (i == 0 || steps[i-1].kind != ROW_WR) settle();
				write_reg(steps[i].idx, steps[i].data,
					i == steps.size() - 1 || steps[i+1].kind != ROW_WR);
			end else begin
				want = steps[i].known ? steps[i].want :
					predict_duty(steps[i].a, steps[i].b, steps[i].c);
				offer_cmd(steps[i].a, steps[i].b, steps[i].c, want);
			end
		end

		// Random blocks under three idling regimes, reconfigured between blocks
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 7;
					sink_idle_pct = 73;
				end
				1: begin
					src_idle_pct  = 73;
					sink_idle_pct = 7;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				settle();
				if ($urandom_range(3) == 0) write_reg(CFG_SPARE, 16'($urandom), 1'b0);
				en_val    = 16'($urandom);
				en_val[0] = ($urandom_range(3) != 0);
				case ($urandom_range(4))
					0:       gain_val = 16'd0;
					1:       gain_val = 16'h7fff;
					2:       gain_val = 16'(RST_INJ_GAIN);
					3:       gain_val = 16'($urandom);
					default: gain_val = 16'($urandom_range(24000));
				endcase
				case ($urandom_range(6))
					0:       per_val = 16'd1;
					1:       per_val = 16'hffff;
					2:       per_val = RST_TIMER_PERIOD;
					3:       per_val = 16'($urandom);
					4:       per_val = ($urandom_range(3) == 0) ? 16'd0 : 16'd8500;
					default: per_val = 16'($urandom_range(9000, 1000));
				endcase
				write_reg(CFG_SVM_ENABLE, en_val, 1'b0);
				write_reg(CFG_INJ_GAIN, gain_val, 1'b0);
				write_reg(CFG_TIMER_PERIOD, per_val, 1'b1);
				if (ph == 2 && blk == 0) burst_go = 1'b1;
				for (int n = 0; n < BLOCK_LEN; n++) begin
					sel = $urandom_range(9);
					if (sel < 6) begin
						a = phase_t'($urandom);
						b = phase_t'($urandom);
						c = phase_t'($urandom);
					end else if (sel < 8) begin
						// Balanced three-phase set, as a current loop would issue
						a   = phase_t'($urandom_range(40000) - 20000);
						b   = phase_t'($urandom_range(40000) - 20000);
						sum = -(int'(a) + int'(b));
						if (sum > 32767) sum = 32767;
						if (sum < -32768) sum = -32768;
						c   = phase_t'(sum);
					end else begin
						a = phase_t'(CORNER_VALS[$urandom_range(4)]);
						b = phase_t'(CORNER_VALS[$urandom_range(4)]);
						c = phase_t'(CORNER_VALS[$urandom_range(4)]);
					end
					offer_cmd(a, b, c, predict_duty(a, b, c));
				end
			end
		end

		settle();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/svpwm_pkg.sv
hdl/svpwm_cfg.sv
hdl/svpwm_zseq.sv
hdl/svpwm_scale.sv
hdl/svpwm_duty_calc_core.sv
dv/tb_top.sv
